@@ rtl/core/tte_pkg.sv @@
// Shared types, command codes and character constants of the terminal escape engine.
package tte_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_COLLECT
    } t_mode;

    typedef enum logic [1:0] {
        PCMD_NORMAL,
        PCMD_SETCOLOR,
        PCMD_REVERSE,
        PCMD_ADDRESS
    } t_pcmd;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_PRINT,
        ACT_PAD,
        ACT_UP,
        ACT_UP_SCROLL,
        ACT_DOWN,
        ACT_DOWN_SCROLL,
        ACT_CLEAR,
        ACT_EOL,
        ACT_SHIFT
    } t_act;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_DECODE,
        OP_TAB_RD_CUR,
        OP_PAD_LD,
        OP_PAD_STEP,
        OP_LEN_WR,
        OP_PRINT,
        OP_ROW_INC,
        OP_ROW_DEC,
        OP_SH_START,
        OP_SH_RD0,
        OP_SH_SAVE,
        OP_SH_SRC_RD,
        OP_SH_MV,
        OP_SH_PUT,
        OP_CLR,
        OP_EOL,
        OP_RD_TAB,
        OP_RD_CELL,
        OP_OUT_LOAD
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE,
        S_PAD_RD,
        S_PAD_LD,
        S_PAD,
        S_PRINT_LEN,
        S_SH_RD0,
        S_SH_SAVE,
        S_SH_CHK,
        S_SH_MV,
        S_CLR,
        S_EOL,
        S_RD_TAB,
        S_RD_CELL,
        S_RD_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic sh_del;
    } t_dp_cmd;

    typedef struct packed {
        logic func;
        t_act act;
        logic pad_more;
        logic wrap;
        logic at_top;
        logic at_bottom;
        logic sh_end;
        logic clr_end;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [6:0] read_char;
        logic [2:0] read_color;
        logic [5:0] cursor_row;
        logic [6:0] cursor_col;
        logic [2:0] current_color;
        logic [2:0] foreground;
        logic [2:0] background;
        logic [2:0] reverse_color;
        logic [2:0] cursor_color;
        logic       keypad_mode;
        logic       bell;
        logic       scrolled;
    } t_result;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    localparam logic FUNC_FEED = 1'b0;

    localparam logic [6:0] CH_BEL   = 7'h07;
    localparam logic [6:0] CH_BS    = 7'h08;
    localparam logic [6:0] CH_TAB   = 7'h09;
    localparam logic [6:0] CH_LF    = 7'h0a;
    localparam logic [6:0] CH_CR    = 7'h0d;
    localparam logic [6:0] CH_ESC   = 7'h1b;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_DEL   = 7'h7f;

    localparam logic [6:0] ESC_NORMAL_CLR = 7'h30;
    localparam logic [6:0] ESC_SET_CLR    = 7'h37;
    localparam logic [6:0] ESC_REVERSE    = 7'h39;
    localparam logic [6:0] ESC_KEYPAD_ON  = 7'h3b;
    localparam logic [6:0] ESC_KEYPAD_OFF = 7'h3e;
    localparam logic [6:0] ESC_UP         = 7'h41;
    localparam logic [6:0] ESC_DOWN       = 7'h42;
    localparam logic [6:0] ESC_RIGHT      = 7'h43;
    localparam logic [6:0] ESC_LEFT       = 7'h44;
    localparam logic [6:0] ESC_HOME       = 7'h48;
    localparam logic [6:0] ESC_REV_INDEX  = 7'h49;
    localparam logic [6:0] ESC_CLR_EOS    = 7'h4a;
    localparam logic [6:0] ESC_CLR_EOL    = 7'h4b;
    localparam logic [6:0] ESC_INS_LINE   = 7'h4c;
    localparam logic [6:0] ESC_DEL_LINE   = 7'h4d;
    localparam logic [6:0] ESC_ADDRESS    = 7'h59;
    localparam logic [6:0] ESC_CLR_PAGE   = 7'h76;

    localparam logic [6:0] SEL_FG_UC  = 7'h46;
    localparam logic [6:0] SEL_FG_LC  = 7'h66;
    localparam logic [6:0] SEL_BG_UC  = 7'h42;
    localparam logic [6:0] SEL_BG_LC  = 7'h62;
    localparam logic [6:0] SEL_REV_UC = 7'h52;
    localparam logic [6:0] SEL_REV_LC = 7'h72;
    localparam logic [6:0] SEL_CUR_UC = 7'h43;
    localparam logic [6:0] SEL_CUR_LC = 7'h63;

    localparam logic [2:0] RST_CUR_CLR = 3'd7;
    localparam logic [2:0] RST_FG      = 3'd7;
    localparam logic [2:0] RST_BG      = 3'd0;
    localparam logic [2:0] RST_REV     = 3'd5;
    localparam logic [2:0] RST_CURSOR  = 3'd7;

    localparam logic [7:0] RST_COLUMNS = 8'd80;
    localparam logic [6:0] RST_ROWS    = 7'd48;

endpackage

@@ rtl/core/tte_ctrl.sv @@
// Sequencing state machine of the terminal escape engine.
module tte_ctrl
    import tte_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_print, n_print;
    logic   r_up, n_up;
    logic   r_mv_scroll, n_mv_scroll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_print     <= 1'b0;
            r_up        <= 1'b0;
            r_mv_scroll <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_print     <= n_print;
            r_up        <= n_up;
            r_mv_scroll <= n_mv_scroll;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_print      = r_print;
        n_up         = r_up;
        n_mv_scroll  = r_mv_scroll;
        o_cmd.op     = OP_NOP;
        o_cmd.sh_del = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.func != FUNC_FEED) begin
                    n_state = S_RD_TAB;
                end else begin
                    o_cmd.op = OP_DECODE;
                    case (i_sts.act) inside
                        ACT_PRINT: begin
                            n_print = 1'b1;
                            n_state = S_PAD_RD;
                        end
                        ACT_PAD: begin
                            n_print = 1'b0;
                            n_state = S_PAD_RD;
                        end
                        ACT_UP, ACT_UP_SCROLL: begin
                            n_up        = 1'b1;
                            n_mv_scroll = (i_sts.act == ACT_UP_SCROLL);
                            n_state     = S_MOVE;
                        end
                        ACT_DOWN, ACT_DOWN_SCROLL: begin
                            n_up        = 1'b0;
                            n_mv_scroll = (i_sts.act == ACT_DOWN_SCROLL);
                            n_state     = S_MOVE;
                        end
                        ACT_CLEAR: n_state = S_CLR;
                        ACT_EOL:   n_state = S_EOL;
                        ACT_SHIFT: n_state = S_SH_RD0;
                        default:   n_state = S_RD_TAB;
                    endcase
                end
            end
            S_MOVE: begin
                n_print = 1'b0;
                if (r_up ? i_sts.at_top : i_sts.at_bottom) begin
                    if (r_mv_scroll) begin
                        o_cmd.op     = OP_SH_START;
                        o_cmd.sh_del = !r_up;
                        n_state      = S_SH_RD0;
                    end else begin
                        n_state = S_RD_TAB;
                    end
                end else begin
                    o_cmd.op = r_up ? OP_ROW_DEC : OP_ROW_INC;
                    n_state  = S_PAD_RD;
                end
            end
            S_PAD_RD: begin
                o_cmd.op = OP_TAB_RD_CUR;
                n_state  = S_PAD_LD;
            end
            S_PAD_LD: begin
                o_cmd.op = OP_PAD_LD;
                n_state  = S_PAD;
            end
            S_PAD: begin
                if (i_sts.pad_more) begin
                    o_cmd.op = OP_PAD_STEP;
                end else if (r_print) begin
                    o_cmd.op = OP_PRINT;
                    n_state  = S_PRINT_LEN;
                end else begin
                    o_cmd.op = OP_LEN_WR;
                    n_state  = S_RD_TAB;
                end
            end
            S_PRINT_LEN: begin
                o_cmd.op = OP_LEN_WR;
                if (i_sts.wrap) begin
                    n_up        = 1'b0;
                    n_mv_scroll = 1'b1;
                    n_state     = S_MOVE;
                end else begin
                    n_state = S_RD_TAB;
                end
            end
            S_SH_RD0: begin
                o_cmd.op = OP_SH_RD0;
                n_state  = S_SH_SAVE;
            end
            S_SH_SAVE: begin
                o_cmd.op = OP_SH_SAVE;
                n_state  = S_SH_CHK;
            end
            S_SH_CHK: begin
                n_print = 1'b0;
                if (i_sts.sh_end) begin
                    o_cmd.op = OP_SH_PUT;
                    n_state  = S_PAD_RD;
                end else begin
                    o_cmd.op = OP_SH_SRC_RD;
                    n_state  = S_SH_MV;
                end
            end
            S_SH_MV: begin
                o_cmd.op = OP_SH_MV;
                n_state  = S_SH_CHK;
            end
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_sts.clr_end) begin
                    n_state = S_RD_TAB;
                end
            end
            S_EOL: begin
                o_cmd.op = OP_EOL;
                n_state  = S_RD_TAB;
            end
            S_RD_TAB: begin
                o_cmd.op = OP_RD_TAB;
                n_state  = S_RD_CELL;
            end
            S_RD_CELL: begin
                o_cmd.op = OP_RD_CELL;
                n_state  = S_RD_OUT;
            end
            S_RD_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_OUT_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/core/tte_datapath.sv @@
// Datapath of the terminal escape engine: parser registers, row tables and cell memory.
module tte_datapath
    import tte_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    input  logic [5:0] i_read_row,
    input  logic [6:0] i_read_col,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_result    o_result,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts
);

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int LEN_W   = $clog2(MAX_COLS + 1);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int NR_W    = $clog2(MAX_ROWS + 1);
    localparam int CELL_N  = MAX_ROWS * MAX_COLS;
    localparam int CELL_AW = $clog2(CELL_N);

    function automatic logic [LEN_W-1:0] clamp_cols(input logic [7:0] v);
        logic [LEN_W-1:0] res;
        if (v < 8'd2) res = LEN_W'(2);
        else if (32'(v) > MAX_COLS) res = LEN_W'(MAX_COLS);
        else res = LEN_W'(v);
        return res;
    endfunction

    function automatic logic [NR_W-1:0] clamp_rows(input logic [6:0] v);
        logic [NR_W-1:0] res;
        if (v < 7'd2) res = NR_W'(2);
        else if (32'(v) > MAX_ROWS) res = NR_W'(MAX_ROWS);
        else res = NR_W'(v);
        return res;
    endfunction

    // configuration and architectural state
    logic [7:0]       r_cols_cfg;
    logic [6:0]       r_rows_cfg;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    t_mode            r_mode;
    t_pcmd            r_pend;
    logic [1:0]       r_args;
    logic [6:0]       r_first;
    logic [2:0]       r_cur, r_fg, r_bg, r_rev, r_cursor;
    logic             r_keypad;

    // per-item working registers
    logic             r_func;
    logic [6:0]       r_byte;
    logic [5:0]       r_rr;
    logic [6:0]       r_rc;
    logic             r_bell, r_scroll;
    logic [ROW_W-1:0] r_wmap;
    logic [LEN_W-1:0] r_wlen;
    logic             r_wrap;
    logic [ROW_W-1:0] r_idx, r_line, r_saved;
    logic             r_del;
    logic             r_rd_ok;
    logic             r_out_valid;
    t_result          r_result;

    // row tables: map and line length memories, each with per-entry valid bits
    logic [ROW_W-1:0] map_mem [MAX_ROWS];
    logic [LEN_W-1:0] len_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_map_vld, r_len_vld;
    logic [ROW_W-1:0] r_map_q, r_rd_idx;
    logic [LEN_W-1:0] r_len_q;
    logic             r_rd_mvld, r_rd_lvld;

    // cell memories
    logic [6:0] char_mem  [CELL_N];
    logic [2:0] color_mem [CELL_N];
    logic [6:0] r_char_q;
    logic [2:0] r_color_q;

    logic [LEN_W-1:0] eff_cols, new_cols;
    logic [NR_W-1:0]  eff_rows, new_rows;
    logic [ROW_W-1:0] last_row, sh_src;
    logic [ROW_W-1:0] map_data;
    logic [LEN_W-1:0] len_data;

    // decode results
    t_act             dec_act;
    logic [ROW_W-1:0] d_row, d_idx, d_line;
    logic [COL_W-1:0] d_col;
    t_mode            d_mode;
    t_pcmd            d_pend;
    logic [1:0]       d_args;
    logic [6:0]       d_first;
    logic [2:0]       d_cur, d_fg, d_bg, d_rev, d_cursor;
    logic             d_keypad, d_bell, d_scroll, d_del;
    logic [31:0]      tab_pos, col_inc;

    logic             map_we, len_we, char_we, color_we;
    logic [ROW_W-1:0] tab_wa, tab_ra, map_wd;
    logic [LEN_W-1:0] len_wd;
    logic [CELL_AW-1:0] cell_wa, cell_ra;
    logic [6:0]       char_wd;

    assign eff_cols = clamp_cols(r_cols_cfg);
    assign eff_rows = clamp_rows(r_rows_cfg);
    assign new_cols = clamp_cols(i_cfg_data);
    assign new_rows = clamp_rows(i_cfg_data[6:0]);
    assign last_row = ROW_W'(eff_rows - NR_W'(1));
    assign sh_src   = r_del ? r_idx + ROW_W'(1) : r_idx - ROW_W'(1);
    assign map_data = r_rd_mvld ? r_map_q : r_rd_idx;
    assign len_data = r_rd_lvld ? r_len_q : '0;
    assign tab_pos  = 32'(r_col) + 32'd8 - (32'(r_col) & 32'd7);
    assign col_inc  = 32'(r_col) + 32'd1;

    always_comb begin
        dec_act  = ACT_NONE;
        d_row    = r_row;
        d_col    = r_col;
        d_mode   = r_mode;
        d_pend   = r_pend;
        d_args   = r_args;
        d_first  = r_first;
        d_cur    = r_cur;
        d_fg     = r_fg;
        d_bg     = r_bg;
        d_rev    = r_rev;
        d_cursor = r_cursor;
        d_keypad = r_keypad;
        d_bell   = r_bell;
        d_scroll = r_scroll;
        d_idx    = r_idx;
        d_line   = r_line;
        d_del    = r_del;
        case (r_mode)
            MODE_ESCAPE: begin
                d_mode = MODE_NORMAL;
                unique case (r_byte)
                    ESC_NORMAL_CLR: begin
                        d_mode = MODE_COLLECT;
                        d_pend = PCMD_NORMAL;
                        d_args = 2'd1;
                    end
                    ESC_SET_CLR: begin
                        d_mode = MODE_COLLECT;
                        d_pend = PCMD_SETCOLOR;
                        d_args = 2'd2;
                    end
                    ESC_REVERSE: begin
                        d_mode = MODE_COLLECT;
                        d_pend = PCMD_REVERSE;
                        d_args = 2'd1;
                    end
                    ESC_ADDRESS: begin
                        d_mode = MODE_COLLECT;
                        d_pend = PCMD_ADDRESS;
                        d_args = 2'd2;
                    end
                    ESC_KEYPAD_ON:  d_keypad = 1'b1;
                    ESC_KEYPAD_OFF: d_keypad = 1'b0;
                    ESC_UP:         dec_act = ACT_UP;
                    ESC_DOWN:       dec_act = ACT_DOWN;
                    ESC_RIGHT: begin
                        if (col_inc < 32'(eff_cols)) begin
                            d_col   = COL_W'(col_inc);
                            dec_act = ACT_PAD;
                        end
                    end
                    ESC_LEFT: begin
                        if (r_col != '0) begin
                            d_col   = r_col - COL_W'(1);
                            dec_act = ACT_PAD;
                        end
                    end
                    ESC_HOME: begin
                        d_row = '0;
                        d_col = '0;
                    end
                    ESC_REV_INDEX: dec_act = ACT_UP_SCROLL;
                    ESC_CLR_PAGE: begin
                        d_row    = '0;
                        d_col    = '0;
                        d_idx    = '0;
                        d_scroll = 1'b1;
                        dec_act  = ACT_CLEAR;
                    end
                    ESC_CLR_EOS: begin
                        d_idx    = r_row;
                        d_scroll = 1'b1;
                        dec_act  = ACT_CLEAR;
                    end
                    ESC_CLR_EOL: dec_act = ACT_EOL;
                    ESC_INS_LINE: begin
                        d_line   = r_row;
                        d_del    = 1'b0;
                        d_idx    = last_row;
                        d_scroll = 1'b1;
                        dec_act  = ACT_SHIFT;
                    end
                    ESC_DEL_LINE: begin
                        d_line   = r_row;
                        d_del    = 1'b1;
                        d_idx    = r_row;
                        d_scroll = 1'b1;
                        dec_act  = ACT_SHIFT;
                    end
                    default: ;
                endcase
            end
            MODE_COLLECT: begin
                if (r_args == 2'd2) begin
                    d_first = r_byte;
                    d_args  = 2'd1;
                end else begin
                    d_args = 2'd0;
                    d_mode = MODE_NORMAL;
                    unique case (r_pend)
                        PCMD_NORMAL:  d_cur = r_fg;
                        PCMD_REVERSE: d_cur = r_rev;
                        PCMD_SETCOLOR: begin
                            case (r_first) inside
                                SEL_FG_UC, SEL_FG_LC:   d_fg     = r_byte[2:0];
                                SEL_BG_UC, SEL_BG_LC:   d_bg     = r_byte[2:0];
                                SEL_REV_UC, SEL_REV_LC: d_rev    = r_byte[2:0];
                                SEL_CUR_UC, SEL_CUR_LC: d_cursor = r_byte[2:0];
                                default: ;
                            endcase
                            d_scroll = 1'b1;
                            d_cur    = d_fg;
                        end
                        default: begin
                            // cursor address: row first, column only if it fits
                            if (r_first >= CH_SPACE &&
                                32'(r_first - CH_SPACE) < 32'(eff_rows)) begin
                                d_row = ROW_W'(r_first - CH_SPACE);
                                if (r_byte >= CH_SPACE &&
                                    32'(r_byte - CH_SPACE) < 32'(eff_cols)) begin
                                    d_col   = COL_W'(r_byte - CH_SPACE);
                                    dec_act = ACT_PAD;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                if (r_byte == CH_DEL) begin
                    dec_act = ACT_NONE;
                end else if (r_byte >= CH_SPACE) begin
                    dec_act = ACT_PRINT;
                end else begin
                    unique case (r_byte)
                        CH_ESC: d_mode = MODE_ESCAPE;
                        CH_BS: begin
                            if (r_col != '0) begin
                                d_col   = r_col - COL_W'(1);
                                dec_act = ACT_PAD;
                            end
                        end
                        CH_BEL: d_bell = 1'b1;
                        CH_TAB: begin
                            // next tab stop, held at the last column
                            if (tab_pos >= 32'(eff_cols)) d_col = COL_W'(eff_cols - LEN_W'(1));
                            else d_col = COL_W'(tab_pos);
                            dec_act = ACT_PAD;
                        end
                        CH_LF:  dec_act = ACT_DOWN_SCROLL;
                        CH_CR:  d_col = '0;
                        default: ;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg  <= RST_COLUMNS;
            r_rows_cfg  <= RST_ROWS;
            r_row       <= '0;
            r_col       <= '0;
            r_mode      <= MODE_NORMAL;
            r_pend      <= PCMD_NORMAL;
            r_args      <= 2'd0;
            r_first     <= 7'd0;
            r_cur       <= RST_CUR_CLR;
            r_fg        <= RST_FG;
            r_bg        <= RST_BG;
            r_rev       <= RST_REV;
            r_cursor    <= RST_CURSOR;
            r_keypad    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                // clamp the cursor into the resized screen
                if (i_cfg_idx == CFG_COLUMNS) begin
                    r_cols_cfg <= i_cfg_data;
                    if (32'(r_col) >= 32'(new_cols)) r_col <= COL_W'(new_cols - LEN_W'(1));
                end else begin
                    r_rows_cfg <= i_cfg_data[6:0];
                    if (32'(r_row) >= 32'(new_rows)) r_row <= ROW_W'(new_rows - NR_W'(1));
                end
            end
            case (i_cmd.op)
                OP_DECODE: begin
                    r_row    <= d_row;
                    r_col    <= d_col;
                    r_mode   <= d_mode;
                    r_pend   <= d_pend;
                    r_args   <= d_args;
                    r_first  <= d_first;
                    r_cur    <= d_cur;
                    r_fg     <= d_fg;
                    r_bg     <= d_bg;
                    r_rev    <= d_rev;
                    r_cursor <= d_cursor;
                    r_keypad <= d_keypad;
                end
                OP_PRINT: begin
                    if (col_inc >= 32'(eff_cols)) r_col <= '0;
                    else r_col <= COL_W'(col_inc);
                end
                OP_ROW_INC: r_row <= r_row + ROW_W'(1);
                OP_ROW_DEC: r_row <= r_row - ROW_W'(1);
                default: ;
            endcase
            if (i_cmd.op == OP_OUT_LOAD) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_func   <= i_func;
                r_byte   <= i_data_byte[6:0];
                r_rr     <= i_read_row;
                r_rc     <= i_read_col;
                r_bell   <= 1'b0;
                r_scroll <= 1'b0;
            end
            OP_DECODE: begin
                r_bell   <= d_bell;
                r_scroll <= d_scroll;
                r_idx    <= d_idx;
                r_line   <= d_line;
                r_del    <= d_del;
            end
            OP_PAD_LD: begin
                r_wmap <= map_data;
                r_wlen <= len_data;
            end
            OP_PAD_STEP: r_wlen <= r_wlen + LEN_W'(1);
            OP_PRINT: begin
                r_wrap <= (col_inc >= 32'(eff_cols));
                if (32'(r_wlen) < col_inc) r_wlen <= LEN_W'(col_inc);
            end
            OP_SH_START: begin
                r_line   <= '0;
                r_del    <= i_cmd.sh_del;
                r_idx    <= i_cmd.sh_del ? '0 : last_row;
                r_scroll <= 1'b1;
            end
            OP_SH_SAVE: r_saved <= map_data;
            OP_SH_MV:   r_idx   <= sh_src;
            OP_CLR:     r_idx   <= r_idx + ROW_W'(1);
            OP_RD_CELL: begin
                r_rd_ok <= (32'(r_rr) < 32'(eff_rows)) && (32'(r_rc) < 32'(eff_cols)) &&
                           (32'(r_rc) < 32'(len_data));
            end
            OP_OUT_LOAD: begin
                r_result.read_char     <= r_rd_ok ? r_char_q : 7'd0;
                r_result.read_color    <= r_rd_ok ? r_color_q : 3'd0;
                r_result.cursor_row    <= 6'(r_row);
                r_result.cursor_col    <= 7'(r_col);
                r_result.current_color <= r_cur;
                r_result.foreground    <= r_fg;
                r_result.background    <= r_bg;
                r_result.reverse_color <= r_rev;
                r_result.cursor_color  <= r_cursor;
                r_result.keypad_mode   <= r_keypad;
                r_result.bell          <= r_bell;
                r_result.scrolled      <= r_scroll;
            end
            default: ;
        endcase
    end

    // row table ports
    always_comb begin
        map_we = (i_cmd.op == OP_SH_MV) || (i_cmd.op == OP_SH_PUT);
        len_we = map_we || (i_cmd.op == OP_LEN_WR) || (i_cmd.op == OP_CLR) ||
                 (i_cmd.op == OP_EOL);
        tab_wa = ((i_cmd.op == OP_LEN_WR) || (i_cmd.op == OP_EOL)) ? r_row : r_idx;
        map_wd = (i_cmd.op == OP_SH_PUT) ? r_saved : map_data;
        case (i_cmd.op)
            OP_LEN_WR: len_wd = r_wlen;
            OP_SH_MV:  len_wd = len_data;
            OP_EOL:    len_wd = LEN_W'(r_col);
            default:   len_wd = '0;
        endcase
        case (i_cmd.op)
            OP_TAB_RD_CUR: tab_ra = r_row;
            OP_SH_RD0:     tab_ra = r_idx;
            OP_SH_SRC_RD:  tab_ra = sh_src;
            default:       tab_ra = ROW_W'(r_rr);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
            r_len_vld <= '0;
        end else begin
            if (map_we) r_map_vld[tab_wa] <= 1'b1;
            if (len_we) r_len_vld[tab_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) map_mem[tab_wa] <= map_wd;
        if (len_we) len_mem[tab_wa] <= len_wd;
        r_map_q   <= map_mem[tab_ra];
        r_len_q   <= len_mem[tab_ra];
        r_rd_idx  <= tab_ra;
        r_rd_mvld <= r_map_vld[tab_ra];
        r_rd_lvld <= r_len_vld[tab_ra];
    end

    // cell memory ports
    always_comb begin
        char_we  = (i_cmd.op == OP_PAD_STEP) || (i_cmd.op == OP_PRINT);
        color_we = (i_cmd.op == OP_PRINT);
        char_wd  = (i_cmd.op == OP_PRINT) ? r_byte : CH_SPACE;
        if (i_cmd.op == OP_PRINT) begin
            cell_wa = CELL_AW'(32'(r_wmap) * MAX_COLS + 32'(r_col));
        end else begin
            cell_wa = CELL_AW'(32'(r_wmap) * MAX_COLS + 32'(r_wlen));
        end
        cell_ra = CELL_AW'(32'(map_data) * MAX_COLS + 32'(COL_W'(r_rc)));
    end

    always_ff @(posedge i_clk) begin
        if (char_we)  char_mem[cell_wa]  <= char_wd;
        if (color_we) color_mem[cell_wa] <= r_cur;
        r_char_q  <= char_mem[cell_ra];
        r_color_q <= color_mem[cell_ra];
    end

    always_comb begin
        o_sts.func      = r_func;
        o_sts.act       = dec_act;
        o_sts.pad_more  = (32'(r_wlen) < 32'(r_col));
        o_sts.wrap      = r_wrap;
        o_sts.at_top    = (r_row == '0);
        o_sts.at_bottom = (32'(r_row) + 32'd1 >= 32'(eff_rows));
        o_sts.sh_end    = (r_idx == (r_del ? last_row : r_line));
        o_sts.clr_end   = (r_idx == last_row);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

@@ rtl/core/text_terminal_escape_engine.sv @@
// Top level of the character-cell terminal engine with VT52-style escapes.
//
// Each input item either feeds one terminal byte (tuser 0) or only reads a
// screen cell (tuser 1); every item returns exactly one result item with the
// cell at read_row/read_col, the cursor, the colors and the bell and scrolled
// flags as they stand after the item. One item is processed at a time: a read
// only or a plain control byte runs load, decode, then a read of the row table
// and cell memory, each a registered-read memory. A printable byte adds a read
// of its row table entry, one write per space padded into a gap, since the cell
// memory has a single write port, then the character and line length writes.
// Line insert, delete and scroll walk the row map one moved row at a time, and
// clear to end of page clears one row at a time, both bounded by screen_rows.
// A new item is accepted as soon as the previous one is finished, even while
// its result still waits in the output register. Configuration writes take
// effect at once and clamp the cursor; issue them only while idle.
module text_terminal_escape_engine
    import tte_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: index 0 screen_columns, 1 screen_rows
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [13:8] read_row, [20:14] read_col, [23:21] zero
    input  logic [23:0] s_axis_tdata,
    // [0] func
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] read_char, [9:7] read_color, [15:10] cursor_row, [22:16] cursor_col,
    // [25:23] current_color, [28:26] foreground, [31:29] background,
    // [34:32] reverse_color, [37:35] cursor_color, [38] keypad_mode,
    // [39] bell, [40] scrolled, [47:41] zero
    output logic [47:0] m_axis_tdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_result res;

    tte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tte_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_func      (s_axis_tuser[0]),
        .i_data_byte (s_axis_tdata[7:0]),
        .i_read_row  (s_axis_tdata[13:8]),
        .i_read_col  (s_axis_tdata[20:14]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (res),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // pack the result, first field in the lowest bits
    assign m_axis_tdata = {7'd0, res.scrolled, res.bell, res.keypad_mode,
                           res.cursor_color, res.reverse_color, res.background,
                           res.foreground, res.current_color, res.cursor_col,
                           res.cursor_row, res.read_color, res.read_char};

endmodule

@@ rtl/core/tte_checker.sv @@
// Port-level checks of the terminal escape engine and their bind.
module tte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_valid,
    input logic        i_s_ready,
    input logic        i_m_valid,
    input logic        i_m_ready,
    input logic [47:0] i_m_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid && !i_m_ready |=> i_m_valid && $stable(i_m_data))
        else $error("result changed while stalled");

    // take one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_valid && i_s_ready |=> !i_s_ready)
        else $error("item accepted while busy");

    // a shown character is a printable or padding character
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid && (i_m_data[6:0] != 7'd0) |-> (i_m_data[6:0] >= 7'h20))
        else $error("control code read from screen");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid |-> (i_m_data[47:41] == 7'd0))
        else $error("nonzero pad bits in result");

endmodule

bind text_terminal_escape_engine tte_checker u_tte_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_valid (s_axis_tvalid),
    .i_s_ready (s_axis_tready),
    .i_m_valid (m_axis_tvalid),
    .i_m_ready (m_axis_tready),
    .i_m_data  (m_axis_tdata)
);
